[rtl/lsc_pkg.sv]
// lsc_pkg: shared codes, reset values and result type for the link session controller.
// No dependencies. Used by lsc_step and link_session_controller.
package lsc_pkg;

    localparam int LSC_TIMER_WIDTH = 8;
    localparam int CFG_WIDTH       = 8;
    localparam int CFG_IDX_WIDTH   = 2;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PING_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RX_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RETRY_DELAY   = 2'd2;

    localparam logic [CFG_WIDTH-1:0] PING_INTERVAL_RST = 8'd5;
    localparam logic [CFG_WIDTH-1:0] RX_TIMEOUT_RST    = 8'd30;
    localparam logic [CFG_WIDTH-1:0] RETRY_DELAY_RST   = 8'd5;

    // event codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_TOKEN = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_NAK   = 3'd3;
    localparam logic [2:0] OP_PONG  = 3'd4;
    localparam logic [2:0] OP_VALID = 3'd5;
    localparam logic [2:0] OP_CLOSE = 3'd6;

    // ack result codes
    localparam logic [1:0] ACK_AUTH   = 2'd0;
    localparam logic [1:0] ACK_CONFIG = 2'd1;
    localparam logic [1:0] ACK_CLOSE  = 2'd2;

    // session states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_LOGIN  = 3'd1;
    localparam logic [2:0] ST_AUTH   = 3'd2;
    localparam logic [2:0] ST_CONFIG = 3'd3;
    localparam logic [2:0] ST_CONN   = 3'd4;
    localparam logic [2:0] ST_CLOSED = 3'd5;

    // packet kinds
    localparam logic [2:0] SEND_NONE   = 3'd0;
    localparam logic [2:0] SEND_LOGIN  = 3'd1;
    localparam logic [2:0] SEND_AUTH   = 3'd2;
    localparam logic [2:0] SEND_CONFIG = 3'd3;
    localparam logic [2:0] SEND_PING   = 3'd4;
    localparam logic [2:0] SEND_CLOSE  = 3'd5;

    typedef struct packed {
        logic       timed_out;
        logic       accepted;
        logic       running;
        logic [2:0] session_state;
        logic [2:0] send_kind;
    } lsc_result_t;

endpackage

[rtl/lsc_step.sv]
// lsc_step: combinational next-state and result logic for one event.
// Depends on lsc_pkg for event, state and packet codes.
module lsc_step import lsc_pkg::*; #(
    parameter int TIMER_WIDTH = LSC_TIMER_WIDTH
) (
    input  logic [2:0]             op,
    input  logic [1:0]             ack_code,
    input  logic [2:0]             phase,
    input  logic [TIMER_WIDTH-1:0] since_send,
    input  logic [TIMER_WIDTH-1:0] since_valid,
    input  logic [TIMER_WIDTH-1:0] backoff_left,
    input  logic [CFG_WIDTH-1:0]   ping_interval,
    input  logic [CFG_WIDTH-1:0]   rx_timeout,
    input  logic [CFG_WIDTH-1:0]   retry_delay,
    output logic [2:0]             phase_next,
    output logic [TIMER_WIDTH-1:0] since_send_next,
    output logic [TIMER_WIDTH-1:0] since_valid_next,
    output logic [TIMER_WIDTH-1:0] backoff_left_next,
    output lsc_result_t            result
);

    // compare width covers both timer and register ranges
    localparam int CW = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    logic [TIMER_WIDTH-1:0] send_inc;
    logic [TIMER_WIDTH-1:0] valid_inc;
    logic                   ping_due;
    logic                   rx_expired;
    logic                   delay_big;

    assign send_inc   = (&since_send)  ? since_send  : since_send  + 1'b1;
    assign valid_inc  = (&since_valid) ? since_valid : since_valid + 1'b1;
    assign ping_due   = CW'(send_inc) > CW'(ping_interval);
    assign rx_expired = CW'(valid_inc) > CW'(rx_timeout);
    assign delay_big  = CW'(retry_delay) > CW'(TMAX);

    always_comb begin
        phase_next           = phase;
        since_send_next      = since_send;
        since_valid_next     = since_valid;
        backoff_left_next    = backoff_left;
        result.send_kind     = SEND_NONE;
        result.running       = 1'b1;
        result.accepted      = 1'b0;
        result.timed_out     = 1'b0;

        case (op)
            OP_TICK: begin
                since_send_next  = send_inc;
                since_valid_next = valid_inc;
                result.accepted  = 1'b1;
                case (phase)
                    ST_INIT: begin
                        if (backoff_left != '0) begin
                            backoff_left_next = backoff_left - 1'b1;
                        end else begin
                            since_send_next  = '0;
                            since_valid_next = '0;
                            result.send_kind = SEND_LOGIN;
                            phase_next       = ST_LOGIN;
                        end
                    end
                    ST_CONN: begin
                        if (ping_due) begin
                            result.send_kind = SEND_PING;
                            since_send_next  = '0;
                        end
                    end
                    ST_CLOSED: begin
                        result.running  = 1'b0;
                        result.accepted = 1'b0;
                    end
                    default: begin
                        // handshake states and unused codes: rx watchdog
                        if (rx_expired) begin
                            phase_next       = ST_INIT;
                            result.timed_out = 1'b1;
                        end
                    end
                endcase
            end
            OP_TOKEN: begin
                if (phase == ST_LOGIN) begin
                    since_send_next  = '0;
                    since_valid_next = '0;
                    result.send_kind = SEND_AUTH;
                    phase_next       = ST_AUTH;
                    result.accepted  = 1'b1;
                end
            end
            OP_ACK: begin
                if (phase == ST_AUTH && ack_code == ACK_AUTH) begin
                    since_send_next  = '0;
                    since_valid_next = '0;
                    result.send_kind = SEND_CONFIG;
                    phase_next       = ST_CONFIG;
                    result.accepted  = 1'b1;
                end else if (phase == ST_CONFIG && ack_code == ACK_CONFIG) begin
                    since_valid_next = '0;
                    phase_next       = ST_CONN;
                    result.accepted  = 1'b1;
                end else if (phase == ST_CONN && ack_code == ACK_CLOSE) begin
                    since_valid_next = '0;
                    phase_next       = ST_CLOSED;
                    result.accepted  = 1'b1;
                end
            end
            OP_NAK: begin
                if (phase == ST_AUTH) begin
                    phase_next        = ST_INIT;
                    backoff_left_next = delay_big ? TMAX : TIMER_WIDTH'(retry_delay);
                    result.accepted   = 1'b1;
                end
            end
            OP_PONG: begin
                if (phase == ST_CONN) begin
                    since_valid_next = '0;
                    result.accepted  = 1'b1;
                end
            end
            OP_VALID: begin
                since_valid_next = '0;
                result.accepted  = 1'b1;
            end
            OP_CLOSE: begin
                since_send_next  = '0;
                result.send_kind = SEND_CLOSE;
                result.accepted  = 1'b1;
            end
            default: begin
            end
        endcase

        result.session_state = phase_next;
    end

endmodule

[rtl/link_session_controller.sv]
// link_session_controller: client session handshake controller, one event per item.
// Path: an accepted item passes the input register, then the result register (m_tvalid).
// Throughput: one item per cycle while m_tready does not stall the result side; session
// state updates in a single pass through lsc_step. Both stages hold under m_tready low,
// so a new item is taken while a result waits only if the input register is empty.
// Reset (aresetn low, synchronous): state init, timers and backoff zero, registers to
// defaults (ping 5, rx timeout 30, retry 5), both stages empty.
module link_session_controller import lsc_pkg::*; #(
    parameter int TIMER_WIDTH = LSC_TIMER_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [2:0] operation, [4:3] ack_code, [7:5] zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // [2:0] send_kind, [5:3] session_state,
                                                // [6] running, [7] accepted, [8] timed_out
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_wdata
);

    logic [CFG_WIDTH-1:0]   ping_interval_reg;
    logic [CFG_WIDTH-1:0]   rx_timeout_reg;
    logic [CFG_WIDTH-1:0]   retry_delay_reg;

    logic [2:0]             phase_reg;
    logic [TIMER_WIDTH-1:0] since_send_reg;
    logic [TIMER_WIDTH-1:0] since_valid_reg;
    logic [TIMER_WIDTH-1:0] backoff_left_reg;

    logic [2:0]             phase_next;
    logic [TIMER_WIDTH-1:0] since_send_next;
    logic [TIMER_WIDTH-1:0] since_valid_next;
    logic [TIMER_WIDTH-1:0] backoff_left_next;

    logic                   in_valid_reg;
    logic [2:0]             in_op_reg;
    logic [1:0]             in_code_reg;
    logic                   out_valid_reg;
    lsc_result_t            out_res_reg;
    lsc_result_t            step_res;

    logic advance;
    logic fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_interval_reg <= PING_INTERVAL_RST;
            rx_timeout_reg    <= RX_TIMEOUT_RST;
            retry_delay_reg   <= RETRY_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PING_INTERVAL: ping_interval_reg <= cfg_wdata;
                REG_RX_TIMEOUT:    rx_timeout_reg    <= cfg_wdata;
                REG_RETRY_DELAY:   retry_delay_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lsc_step #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_step (
        .op                (in_op_reg),
        .ack_code          (in_code_reg),
        .phase             (phase_reg),
        .since_send        (since_send_reg),
        .since_valid       (since_valid_reg),
        .backoff_left      (backoff_left_reg),
        .ping_interval     (ping_interval_reg),
        .rx_timeout        (rx_timeout_reg),
        .retry_delay       (retry_delay_reg),
        .phase_next        (phase_next),
        .since_send_next   (since_send_next),
        .since_valid_next  (since_valid_next),
        .backoff_left_next (backoff_left_next),
        .result            (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= ST_INIT;
            since_send_reg   <= '0;
            since_valid_reg  <= '0;
            backoff_left_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                phase_reg        <= phase_next;
                since_send_reg   <= since_send_next;
                since_valid_reg  <= since_valid_next;
                backoff_left_reg <= backoff_left_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tdata[2:0];
            in_code_reg <= s_tdata[4:3];
        end
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    a_timeout_to_init: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.timed_out |-> out_res_reg.session_state == ST_INIT)
        else $error("timed_out result without init state");

    a_halt_only_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_res_reg.running |->
            out_res_reg.session_state == ST_CLOSED && !out_res_reg.accepted)
        else $error("not running outside closed state");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= ST_CLOSED)
        else $error("session state out of range");

    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(phase_reg) && $stable(since_send_reg) && $stable(backoff_left_reg))
        else $error("session state changed without an item");

endmodule

[test/lsc_checker.sv]
// lsc_checker: watches the event, result and register ports of link_session_controller,
// predicts each session response and compares it with what the block returns.
// Depends on lsc_pkg for codes, register indexes, reset values and lsc_result_t.
module lsc_checker import lsc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [2:0] operation, [4:3] ack_code, [7:5] zero
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [15:0]              m_tdata,   // [2:0] send_kind, [5:3] session_state,
                                                // [6] running, [7] accepted, [8] timed_out
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_wdata,
    output int                       error_count,
    output int                       pending_count,
    output logic [2:0]               session_phase,
    output int                       result_count,
    output int                       ping_count,
    output int                       timeout_count
);

    localparam logic [LSC_TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [CFG_WIDTH-1:0]       ping_ivl;
    logic [CFG_WIDTH-1:0]       rx_limit;
    logic [CFG_WIDTH-1:0]       retry_ticks;
    logic [2:0]                 phase;
    logic [LSC_TIMER_WIDTH-1:0] since_send;
    logic [LSC_TIMER_WIDTH-1:0] since_valid;
    logic [LSC_TIMER_WIDTH-1:0] backoff_left;

    lsc_result_t due_responses[$];
    lsc_result_t forecast;
    lsc_result_t seen;

    function automatic logic [LSC_TIMER_WIDTH-1:0] sat_inc(
        input logic [LSC_TIMER_WIDTH-1:0] v
    );
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    // one session event: updates the session copy and returns the response it causes
    task automatic step_session(input logic [2:0] op, input logic [1:0] code,
                                output lsc_result_t r);
        r.send_kind = SEND_NONE;
        r.running   = 1'b1;
        r.accepted  = 1'b0;
        r.timed_out = 1'b0;
        case (op)
            OP_TICK: begin
                since_send  = sat_inc(since_send);
                since_valid = sat_inc(since_valid);
                r.accepted  = 1'b1;
                case (phase)
                    ST_INIT: begin
                        if (backoff_left != '0) begin
                            backoff_left = backoff_left - 1'b1;
                        end else begin
                            since_send  = '0;
                            since_valid = '0;
                            r.send_kind = SEND_LOGIN;
                            phase       = ST_LOGIN;
                        end
                    end
                    ST_CONN: begin
                        if (since_send > ping_ivl) begin
                            r.send_kind = SEND_PING;
                            since_send  = '0;
                        end
                    end
                    ST_CLOSED: begin
                        r.running  = 1'b0;
                        r.accepted = 1'b0;
                    end
                    default: begin
                        // handshake states give up once the peer has been silent too long
                        if (since_valid > rx_limit) begin
                            phase       = ST_INIT;
                            r.timed_out = 1'b1;
                        end
                    end
                endcase
            end
            OP_TOKEN: begin
                if (phase == ST_LOGIN) begin
                    since_send  = '0;
                    since_valid = '0;
                    r.send_kind = SEND_AUTH;
                    phase       = ST_AUTH;
                    r.accepted  = 1'b1;
                end
            end
            OP_ACK: begin
                if (phase == ST_AUTH && code == ACK_AUTH) begin
                    since_send  = '0;
                    since_valid = '0;
                    r.send_kind = SEND_CONFIG;
                    phase       = ST_CONFIG;
                    r.accepted  = 1'b1;
                end else if (phase == ST_CONFIG && code == ACK_CONFIG) begin
                    since_valid = '0;
                    phase       = ST_CONN;
                    r.accepted  = 1'b1;
                end else if (phase == ST_CONN && code == ACK_CLOSE) begin
                    since_valid = '0;
                    phase       = ST_CLOSED;
                    r.accepted  = 1'b1;
                end
            end
            OP_NAK: begin
                if (phase == ST_AUTH) begin
                    phase        = ST_INIT;
                    backoff_left = (retry_ticks > TIMER_MAX) ? TIMER_MAX : retry_ticks;
                    r.accepted   = 1'b1;
                end
            end
            OP_PONG: begin
                if (phase == ST_CONN) begin
                    since_valid = '0;
                    r.accepted  = 1'b1;
                end
            end
            OP_VALID: begin
                since_valid = '0;
                r.accepted  = 1'b1;
            end
            OP_CLOSE: begin
                since_send  = '0;
                r.send_kind = SEND_CLOSE;
                r.accepted  = 1'b1;
            end
            default: ;
        endcase
        r.session_state = phase;
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ping_ivl     = PING_INTERVAL_RST;
            rx_limit     = RX_TIMEOUT_RST;
            retry_ticks  = RETRY_DELAY_RST;
            phase        = ST_INIT;
            since_send   = '0;
            since_valid  = '0;
            backoff_left = '0;
            due_responses.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PING_INTERVAL: ping_ivl    = cfg_wdata;
                    REG_RX_TIMEOUT:    rx_limit    = cfg_wdata;
                    REG_RETRY_DELAY:   retry_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                step_session(s_tdata[2:0], s_tdata[4:3], forecast);
                due_responses.push_back(forecast);
                if (forecast.send_kind == SEND_PING) ping_count++;
                if (forecast.timed_out) timeout_count++;
            end
            if (m_tvalid && m_tready) begin
                seen = m_tdata[8:0];
                if (due_responses.size() == 0) begin
                    error_count++;
                    $display("%0t: result mismatch, expected none, got %h", $time, m_tdata);
                end else begin
                    forecast = due_responses.pop_front();
                    result_count++;
                    check_field("send_kind", forecast.send_kind, seen.send_kind);
                    check_field("session_state", forecast.session_state, seen.session_state);
                    check_field("running", 3'(forecast.running), 3'(seen.running));
                    check_field("accepted", 3'(forecast.accepted), 3'(seen.accepted));
                    check_field("timed_out", 3'(forecast.timed_out), 3'(seen.timed_out));
                end
            end
        end
        pending_count <= due_responses.size();
        session_phase <= phase;
    end

endmodule

[test/tb_link_session_controller.sv]
// tb_link_session_controller: drives session events and register writes into
// link_session_controller, with bursty input and a stalling result side.
// Depends on lsc_pkg and lsc_checker, which predicts and compares every result.
module tb_link_session_controller;
    import lsc_pkg::*;

    localparam logic [2:0] OP_UNUSED     = 3'd7;
    localparam logic [1:0] ACK_OTHER     = 2'd3;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         HOLD_CYCLES   = 160;
    localparam int         SETTLE_CYCLES = 8;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [15:0]              m_tdata;
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_wdata;

    int         error_count;
    int         pending_count;
    int         result_count;
    int         ping_count;
    int         timeout_count;
    logic [2:0] session_phase;

    int burst_left;
    int event_count;
    int cycle_count;
    bit hold_req;

    link_session_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lsc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .session_phase (session_phase),
        .result_count  (result_count),
        .ping_count    (ping_count),
        .timeout_count (timeout_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: switches among four ready patterns, and on request
    // holds off for a long stretch so the block backs up into its input
    initial begin : receiver
        int          rx_count;
        int          stall_left;
        rx_pattern_t rx_mode;
        bit          hold_taken;
        rx_count   = 0;
        stall_left = 0;
        rx_mode    = RX_STEADY;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                rx_count++;
                if (rx_count % 48 == 0) rx_mode = rx_pattern_t'($urandom_range(0, 3));
                case (rx_mode)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= (rx_count % 4 == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // offers one item and returns right after the edge that accepts it
    task automatic offer(input logic [2:0] op, input logic [1:0] code);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        event_count++;
    endtask

    // stop offering and wait until every response has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_WIDTH-1:0] ping,
                                 input logic [CFG_WIDTH-1:0] rx,
                                 input logic [CFG_WIDTH-1:0] retry);
        write_reg(REG_PING_INTERVAL, ping);
        write_reg(REG_RX_TIMEOUT, rx);
        write_reg(REG_RETRY_DELAY, retry);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // any event; an ack with the banned code is turned into an unknown ack code
    task automatic random_event(input logic [1:0] banned);
        logic [2:0] op;
        logic [1:0] code;
        op   = 3'($urandom_range(0, 7));
        code = 2'($urandom_range(0, 3));
        if (op == OP_ACK && code == banned) code = ACK_OTHER;
        offer(op, code);
    endtask

    // login, token, then either a nak or the auth ack followed by some quiet ticks;
    // the config ack is never sent here, so the session stays in the handshake
    task automatic handshake_attempt();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) offer(OP_TICK, 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 3) == 0) random_event(ACK_CONFIG);
        offer(OP_TOKEN, 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 2) == 0) begin
            offer(OP_NAK, 2'($urandom_range(0, 3)));
        end else begin
            offer(OP_ACK, ACK_AUTH);
            n = $urandom_range(0, 6);
            repeat (n) offer(($urandom_range(0, 4) == 0) ? OP_VALID : OP_TICK,
                             2'($urandom_range(0, 3)));
        end
    endtask

    // walks the session to a handshake state or connected; going backwards relies on
    // a small rx timeout so that a tick drops the handshake to init
    task automatic steer_to(input logic [2:0] target);
        settle();
        while (session_phase != target) begin
            if (session_phase == ST_INIT || session_phase > target) begin
                offer(OP_TICK, 2'($urandom_range(0, 3)));
            end else begin
                case (session_phase)
                    ST_LOGIN: offer(OP_TOKEN, 2'($urandom_range(0, 3)));
                    ST_AUTH:  offer(OP_ACK, ACK_AUTH);
                    default:  offer(OP_ACK, ACK_CONFIG);
                endcase
            end
            settle();
        end
    endtask

    task automatic handshake_stretch(input int goal);
        goal = goal + event_count;
        while (event_count < goal) begin
            if ($urandom_range(0, 4) == 0) random_event(ACK_CONFIG);
            else handshake_attempt();
        end
    endtask

    task automatic connected_stretch(input int goal);
        goal = goal + event_count;
        while (event_count < goal) begin
            if ($urandom_range(0, 1) == 0) offer(OP_TICK, 2'($urandom_range(0, 3)));
            else random_event(ACK_CLOSE);
        end
    endtask

    initial begin
        burst_left  = 0;
        event_count = 0;
        hold_req    = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_PING_INTERVAL;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset registers, every event in init, login and auth sent,
        // nak backoff countdown, ignored acks and events in the wrong state
        offer(OP_TOKEN, ACK_AUTH);
        offer(OP_ACK, ACK_CONFIG);
        offer(OP_PONG, ACK_OTHER);
        offer(OP_UNUSED, ACK_OTHER);
        offer(OP_NAK, ACK_CLOSE);
        offer(OP_VALID, ACK_AUTH);
        offer(OP_CLOSE, ACK_CONFIG);
        offer(OP_TICK, ACK_AUTH);
        offer(OP_ACK, ACK_AUTH);
        offer(OP_NAK, ACK_OTHER);
        offer(OP_TOKEN, ACK_CLOSE);
        offer(OP_TOKEN, ACK_AUTH);
        offer(OP_ACK, ACK_CONFIG);
        offer(OP_ACK, ACK_CLOSE);
        offer(OP_PONG, ACK_AUTH);
        offer(OP_NAK, ACK_AUTH);
        repeat (6) offer(OP_TICK, ACK_OTHER);
        offer(OP_TOKEN, ACK_AUTH);
        offer(OP_ACK, ACK_AUTH);
        offer(OP_ACK, ACK_AUTH);
        offer(OP_NAK, ACK_CONFIG);
        offer(OP_TOKEN, ACK_OTHER);
        offer(OP_CLOSE, ACK_CLOSE);
        settle();

        // zero thresholds: the first quiet tick in any handshake state times out
        load_settings(8'd0, 8'd0, 8'd0);
        repeat (3) offer(OP_TICK, ACK_AUTH);

        // random handshake traffic under several register settings
        handshake_stretch(30);
        settle();
        load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)),
                      8'($urandom_range(1, 3)));
        hold_req = 1'b1;
        handshake_stretch(35);
        settle();
        load_settings(8'd255, 8'd255, 8'd0);
        handshake_stretch(20);
        settle();
        load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(5, 12)), 8'd2);
        handshake_stretch(30);
        settle();

        // long backoff: 40 ticks of countdown before the next login
        load_settings(8'd5, 8'd0, 8'd40);
        steer_to(ST_AUTH);
        offer(OP_NAK, ACK_OTHER);
        repeat (42) offer(OP_TICK, 2'($urandom_range(0, 3)));
        settle();

        // connected: every event once, then random traffic
        load_settings(8'd0, 8'd0, 8'd0);
        steer_to(ST_CONN);
        offer(OP_TICK, ACK_AUTH);
        offer(OP_TICK, ACK_OTHER);
        offer(OP_PONG, ACK_AUTH);
        offer(OP_VALID, ACK_CONFIG);
        offer(OP_CLOSE, ACK_OTHER);
        offer(OP_TOKEN, ACK_AUTH);
        offer(OP_NAK, ACK_AUTH);
        offer(OP_ACK, ACK_AUTH);
        offer(OP_ACK, ACK_CONFIG);
        offer(OP_ACK, ACK_OTHER);
        offer(OP_UNUSED, ACK_CLOSE);
        connected_stretch(20);
        settle();
        load_settings(8'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        connected_stretch(20);
        settle();
        load_settings(8'($urandom_range(0, 10)), 8'd30, 8'd5);
        connected_stretch(20);
        settle();

        // timers pinned at all ones: no ping at 255, then one at 254 if they saturated
        load_settings(8'd255, 8'd0, 8'd0);
        repeat (270) offer(OP_TICK, 2'($urandom_range(0, 3)));
        settle();
        load_settings(8'd254, 8'd0, 8'd0);
        offer(OP_TICK, ACK_OTHER);

        // close the session and poke the closed state
        offer(OP_ACK, ACK_CLOSE);
        offer(OP_TICK, ACK_AUTH);
        offer(OP_CLOSE, ACK_AUTH);
        offer(OP_VALID, ACK_OTHER);
        offer(OP_PONG, ACK_CONFIG);
        offer(OP_TOKEN, ACK_CLOSE);
        offer(OP_NAK, ACK_AUTH);
        offer(OP_ACK, ACK_AUTH);
        offer(OP_ACK, ACK_CONFIG);
        offer(OP_ACK, ACK_CLOSE);
        offer(OP_ACK, ACK_OTHER);
        offer(OP_UNUSED, ACK_AUTH);
        offer(OP_TICK, ACK_CLOSE);
        repeat (12) random_event(ACK_OTHER);
        settle();

        $display("Covered %0d session items and %0d results, with %0d pings and %0d rx timeouts,",
                 event_count, result_count, ping_count, timeout_count);
        $display("from reset through nak backoff, the connected link and into the closed state.");
        if (error_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
